### rtl/ebalu_pkg.sv
// Package for the eight-bit ALU with flags: command codes, flag layout and
// the DAA correction constants. Depends on nothing; used by the ALU and its checker.
package ebalu_pkg;

    // Command codes carried on the command port. Codes 25 to 31 are unused
    // and pass operand_a and the old flags through unchanged.
    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADC    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SBC    = 5'd3,
        CMD_CP     = 5'd4,
        CMD_INC    = 5'd5,
        CMD_DEC    = 5'd6,
        CMD_DAA    = 5'd7,
        CMD_RLCA   = 5'd8,
        CMD_RRCA   = 5'd9,
        CMD_RLA    = 5'd10,
        CMD_RRA    = 5'd11,
        CMD_RLC    = 5'd12,
        CMD_RRC    = 5'd13,
        CMD_RL     = 5'd14,
        CMD_RR     = 5'd15,
        CMD_SLA    = 5'd16,
        CMD_SRA    = 5'd17,
        CMD_SRL    = 5'd18,
        CMD_SWAP   = 5'd19,
        CMD_BIT    = 5'd20,
        CMD_SET    = 5'd21,
        CMD_RES    = 5'd22,
        CMD_ADD16  = 5'd23,
        CMD_ADD_SP = 5'd24
    } cmd_t;

    // Flags packed Z, N, H, C from bit 3 down to bit 0.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLAGS_W = 4;

    // Decimal adjust corrections.
    localparam logic [7:0] DAA_SUB_LO   = 8'hFA;
    localparam logic [7:0] DAA_SUB_HI   = 8'hA0;
    localparam logic [8:0] DAA_ADD_LO   = 9'h006;
    localparam logic [7:0] DAA_ADD_HI   = 8'h60;
    localparam logic [3:0] DAA_NIB_MAX  = 4'h9;
    // Upper five bits of the partly corrected value compared against 0x90.
    localparam logic [4:0] DAA_HIGH_MAX = 5'h09;

endpackage

### rtl/eight_bit_alu_with_flags.sv
// Top level of the eight-bit ALU with flags: input register, single-pass
// combinational ALU and result register. Depends on ebalu_pkg.
//
// Usage:
// The block is a stateless ALU of an eight-bit CPU. An input transaction on
// in_valid/in_stall carries a command, two 16-bit operands, a bit index and
// the old Z/N/H/C flags. For each one, exactly one output transaction on
// out_valid/out_stall carries the new register value and the new flags, in
// the same order as the inputs arrived.
// An accepted transaction is loaded into the input register and moves on into
// the result register, whose output is offered, as soon as that register is open.
// Throughput: one transaction per cycle while out_stall is low, because
// every command is a single short add, compare or shift between the registers.
// Back-pressure: when the receiver holds out_stall while a result is waiting,
// the result register holds its value and the item in the input register
// waits behind it; in_stall is raised only in that case, so at most two
// transactions are in flight. in_stall never depends on in_valid.
// Reset (rst_n low, asynchronous) empties both stages: out_valid drops and
// the transactions in flight are dropped; nothing is replayed after release,
// since the block keeps no state other than those transactions.
module eight_bit_alu_with_flags (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [4:0]                    command,
    input  logic [ebalu_pkg::DATA_W-1:0]  operand_a,
    input  logic [ebalu_pkg::DATA_W-1:0]  operand_b,
    input  logic [2:0]                    bit_index,
    input  logic [ebalu_pkg::FLAGS_W-1:0] flags_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ebalu_pkg::DATA_W-1:0]  result_value,
    output logic [ebalu_pkg::FLAGS_W-1:0] flags_out
);
    import ebalu_pkg::*;

    // Input register stage.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [4:0]         cmd_reg;
    logic [DATA_W-1:0]  a_reg;
    logic [DATA_W-1:0]  b_reg;
    logic [2:0]         bit_reg;
    logic [FLAGS_W-1:0] flags_reg;

    // Result register stage.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  result_reg;
    logic [DATA_W-1:0]  result_next;
    logic [FLAGS_W-1:0] flags_out_reg;
    flags_t             flags_next;

    logic in_accept;
    logic s2_open;
    logic s1_move;

    // Arithmetic temporaries.
    cmd_t               cmd;
    flags_t             f;
    logic [7:0]         a8;
    logic [7:0]         b8;
    logic               ci;
    logic [8:0]         sum9;
    logic [4:0]         sum_nib;
    logic [8:0]         diff9;
    logic [4:0]         diff_nib;
    logic [7:0]         inc8;
    logic [7:0]         dec8;
    logic               daa_lo_adj;
    logic [8:0]         daa_t;
    logic               daa_hi_adj;
    logic [7:0]         daa_add;
    logic [7:0]         daa_sub;
    logic [7:0]         daa_res;
    logic [7:0]         rot8;
    logic               rot_c;
    logic [7:0]         bit_mask;
    logic [16:0]        sum17;
    logic [12:0]        sum13;
    logic [DATA_W-1:0]  sp_off;
    logic [DATA_W-1:0]  sp_sum;
    logic [4:0]         sp_nib;
    logic [8:0]         sp_byte;

    // Handshake: the result register can load when it is empty or being taken.
    assign s2_open   = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && s2_open;
    assign in_stall  = s1_valid_reg && !s2_open;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= command;
            a_reg     <= operand_a;
            b_reg     <= operand_b;
            bit_reg   <= bit_index;
            flags_reg <= flags_in;
        end
        if (s1_move)
        begin
            result_reg    <= result_next;
            flags_out_reg <= flags_next;
        end
    end

    // Shared datapath pieces, all computed from the input register.
    always_comb
    begin
        cmd      = cmd_t'(cmd_reg);
        f        = flags_t'(flags_reg);
        a8       = a_reg[7:0];
        b8       = b_reg[7:0];
        ci       = ((cmd == CMD_ADC) || (cmd == CMD_SBC)) ? f.c : 1'b0;

        sum9     = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
        sum_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci};
        diff9    = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
        diff_nib = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci};
        inc8     = a8 + 8'd1;
        dec8     = a8 - 8'd1;

        // Decimal adjust: the high check sees the value after the low fix.
        daa_lo_adj = f.h || (a8[3:0] > DAA_NIB_MAX);
        daa_t      = {1'b0, a8} + (daa_lo_adj ? DAA_ADD_LO : 9'd0);
        daa_hi_adj = f.c || (daa_t[8:4] > DAA_HIGH_MAX);
        daa_add    = daa_t[7:0] + (daa_hi_adj ? DAA_ADD_HI : 8'd0);
        daa_sub    = a8 + (f.h ? DAA_SUB_LO : 8'd0) + (f.c ? DAA_SUB_HI : 8'd0);
        daa_res    = f.n ? daa_sub : daa_add;

        bit_mask = 8'd1 << bit_reg;

        sum17   = {1'b0, a_reg} + {1'b0, b_reg};
        sum13   = {1'b0, a_reg[11:0]} + {1'b0, b_reg[11:0]};
        sp_off  = {{(DATA_W - BYTE_W){b8[7]}}, b8};
        sp_sum  = a_reg + sp_off;
        sp_nib  = {1'b0, a_reg[3:0]} + {1'b0, b8[3:0]};
        sp_byte = {1'b0, a_reg[7:0]} + {1'b0, b8};

        rot8  = a8;
        rot_c = 1'b0;
        case (cmd)
            CMD_RLCA, CMD_RLC:
            begin
                rot8  = {a8[6:0], a8[7]};
                rot_c = a8[7];
            end
            CMD_RRCA, CMD_RRC:
            begin
                rot8  = {a8[0], a8[7:1]};
                rot_c = a8[0];
            end
            CMD_RLA, CMD_RL:
            begin
                rot8  = {a8[6:0], f.c};
                rot_c = a8[7];
            end
            CMD_RRA, CMD_RR:
            begin
                rot8  = {f.c, a8[7:1]};
                rot_c = a8[0];
            end
            CMD_SLA:
            begin
                rot8  = {a8[6:0], 1'b0};
                rot_c = a8[7];
            end
            CMD_SRA:
            begin
                rot8  = {a8[7], a8[7:1]};
                rot_c = a8[0];
            end
            CMD_SRL:
            begin
                rot8  = {1'b0, a8[7:1]};
                rot_c = a8[0];
            end
            CMD_SWAP:
            begin
                rot8  = {a8[3:0], a8[7:4]};
                rot_c = 1'b0;
            end
            default:
            begin
                rot8  = a8;
                rot_c = 1'b0;
            end
        endcase
    end

    // Result selection.
    always_comb
    begin
        result_next = a_reg;
        flags_next  = f;
        case (cmd)
            CMD_ADD, CMD_ADC:
            begin
                result_next = {8'd0, sum9[7:0]};
                flags_next  = '{z: (sum9[7:0] == 8'd0), n: 1'b0,
                                h: sum_nib[4], c: sum9[8]};
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                result_next = (cmd == CMD_CP) ? a_reg : {8'd0, diff9[7:0]};
                flags_next  = '{z: (diff9[7:0] == 8'd0), n: 1'b1,
                                h: diff_nib[4], c: diff9[8]};
            end
            CMD_INC:
            begin
                result_next = {8'd0, inc8};
                flags_next  = '{z: (inc8 == 8'd0), n: 1'b0,
                                h: (a8[3:0] == 4'hF), c: f.c};
            end
            CMD_DEC:
            begin
                result_next = {8'd0, dec8};
                flags_next  = '{z: (dec8 == 8'd0), n: 1'b1,
                                h: (a8[3:0] == 4'h0), c: f.c};
            end
            CMD_DAA:
            begin
                result_next = {8'd0, daa_res};
                flags_next  = '{z: (daa_res == 8'd0), n: f.n, h: 1'b0,
                                c: f.n ? f.c : daa_hi_adj};
            end
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA:
            begin
                result_next = {8'd0, rot8};
                flags_next  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_c};
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SRL, CMD_SWAP:
            begin
                result_next = {8'd0, rot8};
                flags_next  = '{z: (rot8 == 8'd0), n: 1'b0, h: 1'b0, c: rot_c};
            end
            CMD_BIT:
            begin
                result_next = a_reg;
                flags_next  = '{z: ((a8 & bit_mask) == 8'd0), n: 1'b0,
                                h: 1'b1, c: f.c};
            end
            CMD_SET:
            begin
                result_next = {8'd0, a8 | bit_mask};
            end
            CMD_RES:
            begin
                result_next = {8'd0, a8 & ~bit_mask};
            end
            CMD_ADD16:
            begin
                result_next = sum17[15:0];
                flags_next  = '{z: f.z, n: 1'b0, h: sum13[12], c: sum17[16]};
            end
            CMD_ADD_SP:
            begin
                result_next = sp_sum;
                flags_next  = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_byte[8]};
            end
            default:
            begin
                // Unused codes pass the operand and the old flags through.
                result_next = a_reg;
                flags_next  = f;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign flags_out    = flags_out_reg;

endmodule

### rtl/ebalu_checker.sv
// Port-level checker for the eight-bit ALU with flags, with its bind statement.
// Depends on ebalu_pkg and on the port names of eight_bit_alu_with_flags.
module ebalu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [4:0]  command,
    input logic [15:0] operand_a,
    input logic [15:0] operand_b,
    input logic [2:0]  bit_index,
    input logic [3:0]  flags_in,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result_value,
    input logic [3:0]  flags_out
);
    import ebalu_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_value)
                                      && $stable(flags_out)))
        else $error("stalled result changed or vanished");

    // The input side only pushes back when a result is blocked at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // An accepted transaction reaches the output when the result register is not blocked.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ((in_valid && !in_stall) ##1 !(out_valid && out_stall)) |=> out_valid)
        else $error("result did not appear two cycles after acceptance");

    // A compare leaves the operand unchanged on the output.
    a_cp_value: assert property (@(posedge clk) disable iff (!rst_n)
        ((in_valid && !in_stall && (command == CMD_CP)) ##1 !(out_valid && out_stall))
        |=> (result_value == $past(operand_a, 2)))
        else $error("compare changed the operand");

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (.*);
